// File: sv/rgb_led_matrix_scan_driver_macros.svh
// ----------------------------------------------------------------------------
// rgb led matrix scan driver assertion macros
// concurrent assertion wrappers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef RGB_LED_MATRIX_SCAN_DRIVER_MACROS_SVH
`define RGB_LED_MATRIX_SCAN_DRIVER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RLMSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RLMSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RLMSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define RLMSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: sv/rlmsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmsd_pkg
// shared types and constants of the led matrix scan driver
// ----------------------------------------------------------------------------
package rlmsd_pkg;

    localparam int DEF_COLUMNS   = 64;
    localparam int DEF_SCAN_ROWS = 16;
    localparam int IDLE_W        = 16;
    localparam int ENTRY_W       = 6;   // three planes upper, three planes lower

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [1:0] PLANE_RED   = 2'd0;
    localparam logic [1:0] PLANE_GREEN = 2'd1;
    localparam logic [1:0] PLANE_BLUE  = 2'd2;
    localparam logic [1:0] PLANE_NONE  = 2'd3;

    typedef enum logic [3:0] {
        PH_LOW,
        PH_HIGH,
        PH_DISABLE,
        PH_STROBE_HI,
        PH_STROBE_LO,
        PH_ADDRESS,
        PH_ENABLE,
        PH_TAIL_LOW,
        PH_TAIL_HIGH,
        PH_TAIL_DISABLE,
        PH_IDLE
    } t_phase;

    // pin update carried from the sequencer to the pin stage
    typedef enum logic [2:0] {
        ACT_HOLD,
        ACT_DATA,
        ACT_CLK_HI,
        ACT_OD_SET,
        ACT_STB_HI,
        ACT_STB_LO,
        ACT_ADDR,
        ACT_OD_CLR
    } t_action;

    typedef struct packed {
        logic       shift_clock;
        logic       red_upper;
        logic       red_lower;
        logic       green_upper;
        logic       green_lower;
        logic       blue_upper;
        logic       blue_lower;
        logic       output_disable;
        logic       latch_strobe;
        logic [3:0] row_address;
    } t_pins;

    typedef struct packed {
        logic       is_tick;
        t_action    action;
        logic [1:0] plane;
        logic [3:0] row_addr;
        logic       wr_ok;
        logic       wr_half;
        logic       wr_on;
    } t_s1;

endpackage

// File: sv/rlmsd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmsd_in_if
// input channel: pixel write or scan tick transaction
// ----------------------------------------------------------------------------
interface rlmsd_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [1:0] plane;
    logic [4:0] pixel_row;
    logic [5:0] pixel_column;
    logic       pixel_on;

    modport source (
        output valid, operation, plane, pixel_row, pixel_column, pixel_on,
        input  ready
    );
    modport sink (
        input  valid, operation, plane, pixel_row, pixel_column, pixel_on,
        output ready
    );
endinterface

// File: sv/rlmsd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmsd_out_if
// output channel: panel pin levels after one tick
// ----------------------------------------------------------------------------
interface rlmsd_out_if;
    logic       valid;
    logic       ready;
    logic       shift_clock;
    logic       red_upper;
    logic       red_lower;
    logic       green_upper;
    logic       green_lower;
    logic       blue_upper;
    logic       blue_lower;
    logic       output_disable;
    logic       latch_strobe;
    logic [3:0] row_address;

    modport source (
        output valid, shift_clock, red_upper, red_lower, green_upper, green_lower,
               blue_upper, blue_lower, output_disable, latch_strobe, row_address,
        input  ready
    );
    modport sink (
        input  valid, shift_clock, red_upper, red_lower, green_upper, green_lower,
               blue_upper, blue_lower, output_disable, latch_strobe, row_address,
        output ready
    );
endinterface

// File: sv/rlmsd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmsd_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rlmsd_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/rgb_led_matrix_scan_driver.sv
`timescale 1ns / 1ps
// a tick transaction is held in the s1 stage register, then in the pin register once
// the output register frees up; throughput: one transaction per cycle unless the
// output stalls, set by one framebuffer ram read per item and one read-modify-write
// writeback per pixel write; reset: synchronous; a clearing pass zeroes all
// 2**(clog2(SCAN_ROWS) + clog2(COLUMNS)) ram entries (1024 by default), no input taken meanwhile
// ----------------------------------------------------------------------------
// rgb_led_matrix_scan_driver
// two-half rgb led panel scan sequencer with a ram framebuffer
// ----------------------------------------------------------------------------
`include "rgb_led_matrix_scan_driver_macros.svh"

module rgb_led_matrix_scan_driver
    import rlmsd_pkg::*;
#(
    parameter int COLUMNS   = DEF_COLUMNS,
    parameter int SCAN_ROWS = DEF_SCAN_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDLE_W-1:0] i_cfg_wdata,
    rlmsd_in_if.sink          i_in_ch,
    rlmsd_out_if.source       o_out_ch
);

    // address is {scan row, column}; one entry holds both panel halves
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(SCAN_ROWS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 2 ** AW;

    localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(SCAN_ROWS - 1);

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    t_phase              r_phase, n_phase;
    logic [RW-1:0]       r_scan_row, n_scan_row;
    logic [1:0]          r_plane_idx, n_plane_idx;
    logic [CW-1:0]       r_col_idx, n_col_idx;
    logic [IDLE_W-1:0]   r_idle_cnt, n_idle_cnt;
    logic [IDLE_W-1:0]   r_idle_ticks;

    logic                r_clearing;
    logic [AW-1:0]       r_clr_addr;

    logic                r_s1_valid;
    t_s1                 r_s1, n_s1;
    logic [AW-1:0]       r_s1_addr;

    logic                r_fwd_hit;
    logic [ENTRY_W-1:0]  r_fwd_data;

    logic                r_out_valid;
    t_pins               r_pins, n_pins;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic w_in_ready, w_in_acc, w_tick_acc, w_s1_adv, w_wr_commit;

    // the pin stage retires a tick only when the output register frees up
    assign w_s1_adv   = r_s1_valid && (!r_s1.is_tick || !r_out_valid || o_out_ch.ready);
    assign w_in_ready = !r_clearing && (!r_s1_valid || w_s1_adv);
    assign w_in_acc   = i_in_ch.valid && w_in_ready;
    assign w_tick_acc = w_in_acc && (i_in_ch.operation == OP_TICK);
    assign w_wr_commit = w_s1_adv && !r_s1.is_tick && r_s1.wr_ok;

    assign i_in_ch.ready = w_in_ready;

    // ------------------------------------------------------------------
    // pixel write decode
    // ------------------------------------------------------------------
    logic [6:0]    w_row7;
    logic [8:0]    w_col9;
    logic          w_wr_ok, w_wr_half;
    logic [5:0]    w_srow6;
    logic [CW+5:0] w_col_ext;
    logic [AW-1:0] w_wr_addr;

    assign w_row7    = {2'b00, i_in_ch.pixel_row};
    assign w_col9    = {3'b000, i_in_ch.pixel_column};
    assign w_wr_ok   = (i_in_ch.plane != PLANE_NONE) && (w_row7 < 7'(2 * SCAN_ROWS))
                       && (w_col9 < 9'(COLUMNS));
    assign w_wr_half = w_row7 >= 7'(SCAN_ROWS);
    assign w_srow6   = w_wr_half ? ({1'b0, i_in_ch.pixel_row} - 6'(SCAN_ROWS))
                                 : {1'b0, i_in_ch.pixel_row};
    assign w_col_ext = {{CW{1'b0}}, i_in_ch.pixel_column};
    assign w_wr_addr = {w_srow6[RW-1:0], w_col_ext[CW-1:0]};

    // ------------------------------------------------------------------
    // scan sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_LOW:       n_phase = PH_HIGH;
            PH_HIGH:      n_phase = (r_col_idx == COL_LAST) ? PH_DISABLE : PH_LOW;
            PH_DISABLE:   n_phase = PH_STROBE_HI;
            PH_STROBE_HI: n_phase = PH_STROBE_LO;
            PH_STROBE_LO: n_phase = PH_ADDRESS;
            PH_ADDRESS:   n_phase = PH_ENABLE;
            PH_ENABLE: begin
                if (r_plane_idx != PLANE_BLUE) begin
                    n_phase = PH_LOW;
                end else begin
                    n_phase = (r_scan_row == ROW_LAST) ? PH_TAIL_LOW : PH_LOW;
                end
            end
            PH_TAIL_LOW:  n_phase = PH_TAIL_HIGH;
            PH_TAIL_HIGH: n_phase = (r_col_idx == COL_LAST) ? PH_TAIL_DISABLE : PH_TAIL_LOW;
            PH_TAIL_DISABLE: n_phase = (r_idle_ticks == '0) ? PH_LOW : PH_IDLE;
            PH_IDLE: begin
                if (({1'b0, r_idle_cnt} + 17'd1) >= {1'b0, r_idle_ticks}) begin
                    n_phase = PH_LOW;
                end
            end
            default: n_phase = PH_LOW;
        endcase
    end

    // ------------------------------------------------------------------
    // scan sequencer: outputs (counters, pin action, ram read address)
    // ------------------------------------------------------------------
    logic [RW+3:0] w_row_ext;
    logic [AW-1:0] w_seq_addr;

    assign w_row_ext = {4'b0000, r_scan_row};

    always_comb begin
        n_scan_row  = r_scan_row;
        n_plane_idx = r_plane_idx;
        n_col_idx   = r_col_idx;
        n_idle_cnt  = r_idle_cnt;
        w_seq_addr  = {r_scan_row, r_col_idx};
        n_s1        = '0;
        n_s1.is_tick = 1'b1;
        n_s1.action  = ACT_HOLD;
        n_s1.plane   = r_plane_idx;
        n_s1.row_addr = w_row_ext[3:0];
        unique case (r_phase)
            PH_LOW: begin
                n_s1.action = ACT_DATA;
            end
            PH_HIGH, PH_TAIL_HIGH: begin
                n_s1.action = ACT_CLK_HI;
                n_col_idx   = (r_col_idx == COL_LAST) ? '0 : r_col_idx + CW'(1);
            end
            PH_DISABLE: n_s1.action = ACT_OD_SET;
            PH_STROBE_HI: n_s1.action = ACT_STB_HI;
            PH_STROBE_LO: n_s1.action = ACT_STB_LO;
            PH_ADDRESS: n_s1.action = ACT_ADDR;
            PH_ENABLE: begin
                n_s1.action = ACT_OD_CLR;
                n_col_idx   = '0;
                if (r_plane_idx != PLANE_BLUE) begin
                    n_plane_idx = r_plane_idx + 2'd1;
                end else begin
                    n_plane_idx = PLANE_RED;
                    n_scan_row  = (r_scan_row == ROW_LAST) ? '0 : r_scan_row + RW'(1);
                end
            end
            PH_TAIL_LOW: begin
                // final blue row shifted once more
                n_s1.action = ACT_DATA;
                n_s1.plane  = PLANE_BLUE;
                w_seq_addr  = {ROW_LAST, r_col_idx};
            end
            PH_TAIL_DISABLE: begin
                n_s1.action = ACT_OD_SET;
                n_scan_row  = '0;
                n_plane_idx = PLANE_RED;
                n_col_idx   = '0;
                n_idle_cnt  = '0;
            end
            PH_IDLE: begin
                if (({1'b0, r_idle_cnt} + 17'd1) >= {1'b0, r_idle_ticks}) begin
                    n_idle_cnt = '0;
                end else begin
                    n_idle_cnt = r_idle_cnt + IDLE_W'(1);
                end
            end
            default: n_s1.action = ACT_HOLD;
        endcase

        // pixel writes take the write fields instead
        if (i_in_ch.operation == OP_WRITE) begin
            n_s1.is_tick = 1'b0;
            n_s1.action  = ACT_HOLD;
            n_s1.plane   = i_in_ch.plane;
            n_s1.wr_ok   = w_wr_ok;
            n_s1.wr_half = w_wr_half;
            n_s1.wr_on   = i_in_ch.pixel_on;
        end
    end

    logic [AW-1:0] w_rd_addr;
    assign w_rd_addr = (i_in_ch.operation == OP_WRITE) ? w_wr_addr : w_seq_addr;

    // ------------------------------------------------------------------
    // framebuffer ram
    // ------------------------------------------------------------------
    logic               w_ram_we;
    logic [AW-1:0]      w_ram_waddr;
    logic [ENTRY_W-1:0] w_ram_wdata, w_ram_rdata, w_entry, w_new_entry;
    logic [2:0]         w_bit_idx;

    // forwarded copy covers a read issued with a same-address writeback
    assign w_entry   = r_fwd_hit ? r_fwd_data : w_ram_rdata;
    assign w_bit_idx = r_s1.wr_half ? (3'(r_s1.plane) + 3'd3) : 3'(r_s1.plane);

    always_comb begin
        w_new_entry = w_entry;
        w_new_entry[w_bit_idx] = r_s1.wr_on;
    end

    assign w_ram_we    = r_clearing || w_wr_commit;
    assign w_ram_waddr = r_clearing ? r_clr_addr : r_s1_addr;
    assign w_ram_wdata = r_clearing ? '0 : w_new_entry;

    rlmsd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_fb_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_in_acc),
        .i_raddr (w_rd_addr),
        .o_rdata (w_ram_rdata)
    );

    // ------------------------------------------------------------------
    // pin stage
    // ------------------------------------------------------------------
    logic w_up, w_lo;
    assign w_up = w_entry[3'(r_s1.plane)];
    assign w_lo = w_entry[3'(r_s1.plane) + 3'd3];

    always_comb begin
        n_pins = r_pins;
        unique case (r_s1.action)
            ACT_DATA: begin
                // only the active plane carries data, the other pairs go low
                n_pins.shift_clock = 1'b0;
                n_pins.red_upper   = 1'b0;
                n_pins.red_lower   = 1'b0;
                n_pins.green_upper = 1'b0;
                n_pins.green_lower = 1'b0;
                n_pins.blue_upper  = 1'b0;
                n_pins.blue_lower  = 1'b0;
                case (r_s1.plane)
                    PLANE_RED: begin
                        n_pins.red_upper = w_up;
                        n_pins.red_lower = w_lo;
                    end
                    PLANE_GREEN: begin
                        n_pins.green_upper = w_up;
                        n_pins.green_lower = w_lo;
                    end
                    default: begin
                        n_pins.blue_upper = w_up;
                        n_pins.blue_lower = w_lo;
                    end
                endcase
            end
            ACT_CLK_HI: n_pins.shift_clock    = 1'b1;
            ACT_OD_SET: n_pins.output_disable = 1'b1;
            ACT_STB_HI: n_pins.latch_strobe   = 1'b1;
            ACT_STB_LO: n_pins.latch_strobe   = 1'b0;
            ACT_ADDR:   n_pins.row_address    = r_s1.row_addr;
            ACT_OD_CLR: n_pins.output_disable = 1'b0;
            default:    n_pins = r_pins;
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LOW;
            r_scan_row   <= '0;
            r_plane_idx  <= PLANE_RED;
            r_col_idx    <= '0;
            r_idle_cnt   <= '0;
            r_idle_ticks <= '0;
            r_clearing   <= 1'b1;
            r_clr_addr   <= '0;
            r_s1_valid   <= 1'b0;
            r_fwd_hit    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pins       <= '{output_disable: 1'b1, default: '0};
        end else begin
            if (i_cfg_we) begin
                r_idle_ticks <= i_cfg_wdata;
            end

            // clearing pass over the whole framebuffer
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == {AW{1'b1}}) begin
                    r_clearing <= 1'b0;
                end
            end

            if (w_tick_acc) begin
                r_phase     <= n_phase;
                r_scan_row  <= n_scan_row;
                r_plane_idx <= n_plane_idx;
                r_col_idx   <= n_col_idx;
                r_idle_cnt  <= n_idle_cnt;
            end

            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= w_wr_commit && (r_s1_addr == w_rd_addr);
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (w_s1_adv && r_s1.is_tick) begin
                r_out_valid <= 1'b1;
                r_pins      <= n_pins;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1       <= n_s1;
            r_s1_addr  <= w_rd_addr;
            r_fwd_data <= w_new_entry;
        end
    end

    // ------------------------------------------------------------------
    // output channel
    // ------------------------------------------------------------------
    assign o_out_ch.valid          = r_out_valid;
    assign o_out_ch.shift_clock    = r_pins.shift_clock;
    assign o_out_ch.red_upper      = r_pins.red_upper;
    assign o_out_ch.red_lower      = r_pins.red_lower;
    assign o_out_ch.green_upper    = r_pins.green_upper;
    assign o_out_ch.green_lower    = r_pins.green_lower;
    assign o_out_ch.blue_upper     = r_pins.blue_upper;
    assign o_out_ch.blue_lower     = r_pins.blue_lower;
    assign o_out_ch.output_disable = r_pins.output_disable;
    assign o_out_ch.latch_strobe   = r_pins.latch_strobe;
    assign o_out_ch.row_address    = r_pins.row_address;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `RLMSD_ASSERT_IMP(a_no_accept_clear, i_clk, i_rst_n, r_clearing, !w_in_ready, "input taken during clear")
    `RLMSD_ASSERT_IMP(a_s1_empty_clear, i_clk, i_rst_n, r_clearing, !r_s1_valid, "pin stage busy during clear")
    `RLMSD_ASSERT_NXT(a_data_clk_low, i_clk, i_rst_n, w_s1_adv && r_s1.is_tick && (r_s1.action == ACT_DATA), r_out_valid && !r_pins.shift_clock, "data step without low clock")
    `RLMSD_ASSERT_IMP(a_strobe_blanked, i_clk, i_rst_n, r_pins.latch_strobe, r_pins.output_disable, "strobe while output enabled")

endmodule

// File: bench/tb_rgb_led_matrix_scan_driver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_led_matrix_scan_driver
// self-checking bench for the two-half led panel scan driver: pixel writes and
// scan ticks go in with random gaps, every tick's pin levels are predicted and
// compared field by field, across several idle-gap settings written between
// phases, with random and long stalls on the result side
// ----------------------------------------------------------------------------
module tb_rgb_led_matrix_scan_driver;
    import rlmsd_pkg::*;

    localparam int PANEL_ROWS = 2 * DEF_SCAN_ROWS;
    localparam bit [5:0] LAST_COL = 6'(DEF_COLUMNS - 1);
    localparam bit [3:0] LAST_ROW = 4'(DEF_SCAN_ROWS - 1);

    // longest quiet stretch of a correct run is the reset clearing pass;
    // the long result hold is far shorter
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int LONG_HOLD      = 100;
    localparam int PRINT_CAP      = 40;

    typedef struct packed {
        logic       operation;
        logic [1:0] plane;
        logic [4:0] pixel_row;
        logic [5:0] pixel_column;
        logic       pixel_on;
    } scan_item_t;

    // ------------------------------------------------------------------------
    // predictor of the panel sequencer plus the queue of expected pin levels
    // ------------------------------------------------------------------------
    class panel_scoreboard;
        bit [2:0]    frame_bits [PANEL_ROWS][DEF_COLUMNS];
        bit [3:0]    scan_row;
        bit [1:0]    plane_sel;
        bit [5:0]    column;
        t_phase      phase;
        bit [15:0]   idle_count;
        bit [15:0]   idle_ticks;
        t_pins       pins;
        t_pins       expected_pins [$];
        int unsigned errors, results_checked;
        int unsigned writes_seen, writes_dropped, ticks_seen;

        function new();
            restart_frame();
            pins                = '0;
            pins.output_disable = 1'b1;
            idle_ticks          = '0;
        endfunction

        function void restart_frame();
            scan_row   = '0;
            plane_sel  = PLANE_RED;
            column     = '0;
            idle_count = '0;
            phase      = PH_LOW;
        endfunction

        // clock-low step: only the active plane carries pixel bits
        function void drive_data_pins(bit [3:0] row, bit [5:0] col, bit [1:0] pl);
            bit [2:0] upper, lower;
            upper = frame_bits[row][col];
            lower = frame_bits[int'(row) + DEF_SCAN_ROWS][col];
            pins.shift_clock = 1'b0;
            pins.red_upper   = (pl == PLANE_RED)   && upper[PLANE_RED];
            pins.red_lower   = (pl == PLANE_RED)   && lower[PLANE_RED];
            pins.green_upper = (pl == PLANE_GREEN) && upper[PLANE_GREEN];
            pins.green_lower = (pl == PLANE_GREEN) && lower[PLANE_GREEN];
            pins.blue_upper  = (pl == PLANE_BLUE)  && upper[PLANE_BLUE];
            pins.blue_lower  = (pl == PLANE_BLUE)  && lower[PLANE_BLUE];
        endfunction

        function void step_scan();
            case (phase)
                PH_LOW: begin
                    drive_data_pins(scan_row, column, plane_sel);
                    phase = PH_HIGH;
                end
                PH_HIGH: begin
                    pins.shift_clock = 1'b1;
                    phase = (column == LAST_COL) ? PH_DISABLE : PH_LOW;
                    column++;
                end
                PH_DISABLE: begin
                    pins.output_disable = 1'b1;
                    phase = PH_STROBE_HI;
                end
                PH_STROBE_HI: begin
                    pins.latch_strobe = 1'b1;
                    phase = PH_STROBE_LO;
                end
                PH_STROBE_LO: begin
                    pins.latch_strobe = 1'b0;
                    phase = PH_ADDRESS;
                end
                PH_ADDRESS: begin
                    pins.row_address = scan_row;
                    phase = PH_ENABLE;
                end
                PH_ENABLE: begin
                    pins.output_disable = 1'b0;
                    column = '0;
                    if (plane_sel != PLANE_BLUE) begin
                        plane_sel++;
                        phase = PH_LOW;
                    end else begin
                        plane_sel = PLANE_RED;
                        phase = (scan_row == LAST_ROW) ? PH_TAIL_LOW : PH_LOW;
                        scan_row++;
                    end
                end
                PH_TAIL_LOW: begin
                    drive_data_pins(LAST_ROW, column, PLANE_BLUE);
                    phase = PH_TAIL_HIGH;
                end
                PH_TAIL_HIGH: begin
                    pins.shift_clock = 1'b1;
                    phase = (column == LAST_COL) ? PH_TAIL_DISABLE : PH_TAIL_LOW;
                    column++;
                end
                PH_TAIL_DISABLE: begin
                    pins.output_disable = 1'b1;
                    if (idle_ticks == 0) begin
                        restart_frame();
                    end else begin
                        idle_count = '0;
                        phase = PH_IDLE;
                    end
                end
                default: begin
                    // idle gap, ends as soon as the count reaches the setting
                    idle_count++;
                    if (idle_count >= idle_ticks) restart_frame();
                end
            endcase
        endfunction

        function void note_input(scan_item_t it);
            if (it.operation == OP_WRITE) begin
                writes_seen++;
                if (it.plane == PLANE_NONE)
                    writes_dropped++;
                else
                    frame_bits[it.pixel_row][it.pixel_column][it.plane] = it.pixel_on;
            end else begin
                ticks_seen++;
                step_scan();
                expected_pins.push_back(pins);
            end
        endfunction

        function int unsigned pending();
            return expected_pins.size();
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            if (errors < PRINT_CAP)
                $display("%0t ns: result %0d %s got %0h want %0h",
                         $realtime, results_checked, what, got, want);
            errors++;
        endtask

        task check_result(t_pins got);
            t_pins want;
            results_checked++;
            if (expected_pins.size() == 0) begin
                report("unexpected transaction, pins", got, 0);
                return;
            end
            want = expected_pins.pop_front();
            if (got.shift_clock !== want.shift_clock)
                report("shift_clock", got.shift_clock, want.shift_clock);
            if (got.red_upper !== want.red_upper)
                report("red_upper", got.red_upper, want.red_upper);
            if (got.red_lower !== want.red_lower)
                report("red_lower", got.red_lower, want.red_lower);
            if (got.green_upper !== want.green_upper)
                report("green_upper", got.green_upper, want.green_upper);
            if (got.green_lower !== want.green_lower)
                report("green_lower", got.green_lower, want.green_lower);
            if (got.blue_upper !== want.blue_upper)
                report("blue_upper", got.blue_upper, want.blue_upper);
            if (got.blue_lower !== want.blue_lower)
                report("blue_lower", got.blue_lower, want.blue_lower);
            if (got.output_disable !== want.output_disable)
                report("output_disable", got.output_disable, want.output_disable);
            if (got.latch_strobe !== want.latch_strobe)
                report("latch_strobe", got.latch_strobe, want.latch_strobe);
            if (got.row_address !== want.row_address)
                report("row_address", got.row_address, want.row_address);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block itself
    // ------------------------------------------------------------------------
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [IDLE_W-1:0] i_cfg_wdata = '0;

    rlmsd_in_if  in_ch ();
    rlmsd_out_if out_ch ();

    panel_scoreboard scoreboard = new();

    // gap shaping shared by the sender and the result sink
    bit          src_calm     = 1'b0;  // sender offers back to back
    bit          sink_calm    = 1'b0;  // sink keeps ready high
    bit          hold_request = 1'b0;  // one long result hold wanted
    int unsigned holds_done   = 0;

    always #1 i_clk = ~i_clk;

    rgb_led_matrix_scan_driver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch)
    );

    // ------------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------------
    function automatic scan_item_t make_write(logic [1:0] pl, logic [4:0] row,
                                              logic [5:0] col, logic on);
        scan_item_t it;
        it.operation    = OP_WRITE;
        it.plane        = pl;
        it.pixel_row    = row;
        it.pixel_column = col;
        it.pixel_on     = on;
        return it;
    endfunction

    function automatic scan_item_t make_tick();
        scan_item_t it;
        it              = '0;
        it.operation    = OP_TICK;
        return it;
    endfunction

    // ticks carry random junk in the other fields, the block must ignore it
    function automatic scan_item_t random_item();
        scan_item_t it;
        it.operation    = ($urandom_range(0, 99) < 80) ? OP_TICK : OP_WRITE;
        it.plane        = ($urandom_range(0, 15) == 0) ? PLANE_NONE
                                                       : 2'($urandom_range(0, 2));
        it.pixel_row    = 5'($urandom_range(0, PANEL_ROWS - 1));
        it.pixel_column = 6'($urandom_range(0, DEF_COLUMNS - 1));
        it.pixel_on     = ($urandom_range(0, 99) < 60);
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // sender: optional random gap, then hold the transaction until accepted
    // ------------------------------------------------------------------------
    task automatic send_item(scan_item_t it);
        int unsigned gap;
        gap = src_calm ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= it.operation;
        in_ch.plane        <= it.plane;
        in_ch.pixel_row    <= it.pixel_row;
        in_ch.pixel_column <= it.pixel_column;
        in_ch.pixel_on     <= it.pixel_on;
        do @(posedge i_clk); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
        scoreboard.note_input(it);
    endtask

    // random phase of a given number of items; optionally asks the sink for
    // long holds while the sender keeps pushing
    task automatic run_random(int unsigned num_items, bit with_hold);
        int unsigned items_sent;
        items_sent = 0;
        while (items_sent < num_items) begin
            if (items_sent % 200 == 0) begin
                src_calm  = ($urandom_range(0, 3) == 0);
                sink_calm = ($urandom_range(0, 3) == 0);
            end
            if (with_hold && (items_sent == 200 || items_sent == 500)) begin
                src_calm     = 1'b1;
                hold_request = 1'b1;
            end
            send_item(random_item());
            items_sent++;
        end
    endtask

    // stop offering, wait for every expected result, then let a pending
    // pixel writeback finish before the register is touched
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idle_ticks(logic [IDLE_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        scoreboard.idle_ticks = value;
    endtask

    // ------------------------------------------------------------------------
    // result sink: draws a stall per transaction, or one long hold on request,
    // counted here for the closing report, while the sender keeps the block's input backed up
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned stall;
        t_pins       got;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                holds_done++;
                stall = LONG_HOLD;
            end else begin
                stall = sink_calm ? 0 : $urandom_range(0, 4);
            end
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
            got.shift_clock    = out_ch.shift_clock;
            got.red_upper      = out_ch.red_upper;
            got.red_lower      = out_ch.red_lower;
            got.green_upper    = out_ch.green_upper;
            got.green_lower    = out_ch.green_lower;
            got.blue_upper     = out_ch.blue_upper;
            got.blue_lower     = out_ch.blue_lower;
            got.output_disable = out_ch.output_disable;
            got.latch_strobe   = out_ch.latch_strobe;
            got.row_address    = out_ch.row_address;
            scoreboard.check_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends the run after too many cycles with no transaction
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: %0d cycles without a transaction, %0d results outstanding",
                 WATCHDOG_LIMIT, scoreboard.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        in_ch.valid        <= 1'b0;
        in_ch.operation    <= OP_WRITE;
        in_ch.plane        <= PLANE_RED;
        in_ch.pixel_row    <= '0;
        in_ch.pixel_column <= '0;
        in_ch.pixel_on     <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset value written explicitly
        set_idle_ticks('0);

        // directed: corner pixels of both halves, a set then clear, writes to
        // the unused plane code, then ticks (one with every ignored field high)
        send_item(make_write(PLANE_RED,   5'd0,  6'd0,  1'b1));
        send_item(make_write(PLANE_RED,   5'd16, 6'd0,  1'b1));
        send_item(make_write(PLANE_GREEN, 5'd0,  6'd0,  1'b1));
        send_item(make_write(PLANE_BLUE,  5'd31, 6'd63, 1'b1));
        send_item(make_write(PLANE_BLUE,  5'd15, 6'd63, 1'b1));
        send_item(make_write(PLANE_GREEN, 5'd31, 6'd63, 1'b1));
        send_item(make_write(PLANE_GREEN, 5'd31, 6'd63, 1'b0));
        send_item(make_write(PLANE_NONE,  5'd0,  6'd1,  1'b1));
        send_item(make_write(PLANE_NONE,  5'd31, 6'd63, 1'b1));
        send_item(make_write(PLANE_RED,   5'd0,  6'd1,  1'b0));
        send_item(make_write(PLANE_BLUE,  5'd15, 6'd0,  1'b1));
        send_item('1);
        repeat (11) send_item(make_tick());

        // idle setting zero, with two long result holds on the way
        run_random(700, 1'b1);

        // idle setting rewritten mid-frame; the sequencer only uses it at the
        // frame tail, so the scan must carry on unchanged
        settle();
        set_idle_ticks(16'd3);
        run_random(280, 1'b0);

        settle();
        set_idle_ticks(16'hFFFF);
        run_random(250, 1'b0);

        settle();
        set_idle_ticks(16'd1);
        run_random(250, 1'b0);

        settle();

        $display("covered %0d pixel writes (%0d to the unused plane) and %0d scan ticks",
                 scoreboard.writes_seen, scoreboard.writes_dropped, scoreboard.ticks_seen);
        $display("idle_ticks rewritten between phases (0/3/65535/1), %0d long result holds",
                 holds_done);
        if (scoreboard.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d field mismatches", scoreboard.errors);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
